@@ rtl/static_linked_list_allocator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the slot allocator
// Clocked, reset-qualified concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define STATIC_LINKED_LIST_ALLOCATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// assertion on an explicit clock and reset
`define SLLA_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assertion on the block clock and reset
`define SLLA_ASSERT(label, prop, msg) \
   `SLLA_ASSERT_CLK(label, clock, reset, prop, msg)
`else
`define SLLA_ASSERT_CLK(label, clk, rst, prop, msg)
`define SLLA_ASSERT(label, prop, msg)
`endif

`endif

@@ rtl/slla_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared constants, control word layout and the microcode program.
// ----------------------------------------------------------------------------
package slla_pkg;

   // default sizes
   localparam int DEF_CAPACITY   = 256;
   localparam int DEF_DATA_WIDTH = 32;

   // list heads
   localparam int FREE_HEAD = 0;
   localparam int USED_HEAD = 1;

   // port field widths
   localparam int PAYLOAD_W   = 32;
   localparam int SLOT_W      = 8;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // operand select for link addresses and data
   typedef enum logic [2:0] {
      SEL_FREE,
      SEL_USED,
      SEL_IDX,
      SEL_X,
      SEL_Y,
      SEL_RN,
      SEL_RP
   } sel_type;

   // branch conditions
   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_RN_ZERO,
      COND_FULL,
      COND_RANGE_BAD,
      COND_NOT_USED
   } cond_type;

   // how a step ends the program
   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_QUIET,
      FIN_RESULT
   } fin_type;

   // slot register load
   typedef enum logic [1:0] {
      IDX_KEEP,
      IDX_RN,
      IDX_HW
   } idxld_type;

   // temp register load
   typedef enum logic [1:0] {
      TMP_KEEP,
      TMP_RN,
      TMP_RP
   } tmp_type;

   // program counter
   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   // push program
   localparam step_type STEP_P0    = 4'd0;
   localparam step_type STEP_P1    = 4'd1;
   localparam step_type STEP_P2    = 4'd2;
   localparam step_type STEP_P3    = 4'd3;
   localparam step_type STEP_P4    = 4'd4;
   localparam step_type STEP_PN    = 4'd5;
   localparam step_type STEP_PN2   = 4'd6;
   localparam step_type STEP_PFULL = 4'd7;
   // pop program
   localparam step_type STEP_Q0    = 4'd8;
   localparam step_type STEP_Q1    = 4'd9;
   localparam step_type STEP_Q2    = 4'd10;
   localparam step_type STEP_Q3    = 4'd11;
   localparam step_type STEP_Q4    = 4'd12;
   localparam step_type STEP_QBAD  = 4'd13;
   // head setup after reset
   localparam step_type STEP_I0    = 4'd14;
   localparam step_type STEP_I1    = 4'd15;

   // one control word
   typedef struct packed {
      sel_type    nx_ra;
      sel_type    pv_ra;
      logic       nx_we;
      sel_type    nx_wa;
      sel_type    nx_wd;
      logic       pv_we;
      sel_type    pv_wa;
      sel_type    pv_wd;
      logic       use_we;
      logic       use_wd;
      logic       dat_we;
      idxld_type  idx_ld;
      tmp_type    x_ld;
      tmp_type    y_ld;
      cond_type   cond;
      step_type   target;
      fin_type    fin;
      status_type status;
      logic       grant;
   } ctl_type;

   // sequencer condition inputs
   typedef struct packed {
      logic rn_zero;
      logic full;
      logic range_bad;
      logic in_use;
   } flag_type;

   localparam ctl_type CTL_NOP = '{
      nx_ra:  SEL_FREE, pv_ra: SEL_FREE,
      nx_we:  1'b0, nx_wa: SEL_FREE, nx_wd: SEL_FREE,
      pv_we:  1'b0, pv_wa: SEL_FREE, pv_wd: SEL_FREE,
      use_we: 1'b0, use_wd: 1'b0, dat_we: 1'b0,
      idx_ld: IDX_KEEP, x_ld: TMP_KEEP, y_ld: TMP_KEEP,
      cond:   COND_NONE, target: STEP_P0,
      fin:    FIN_NONE, status: STATUS_OK, grant: 1'b0
   };

   // microcode store
   function automatic ctl_type rom_word(input step_type pc);
      ctl_type w;
      w = CTL_NOP;
      unique case (pc)
         // read first free slot
         STEP_P0: begin
            w.nx_ra = SEL_FREE;
         end
         // take it, read its successor; empty free list goes to fresh slot, or to full
         STEP_P1: begin
            w.idx_ld = IDX_RN;
            w.nx_ra  = SEL_RN;
            w.cond   = COND_RN_ZERO;
            w.target = STEP_PN;
         end
         // unlink from free list, read first used slot
         STEP_P2: begin
            w.nx_we = 1'b1; w.nx_wa = SEL_FREE; w.nx_wd = SEL_RN;
            w.pv_we = 1'b1; w.pv_wa = SEL_RN;   w.pv_wd = SEL_FREE;
            w.nx_ra = SEL_USED;
         end
         // link new slot in front of the used list
         STEP_P3: begin
            w.pv_we = 1'b1; w.pv_wa = SEL_IDX; w.pv_wd = SEL_USED;
            w.nx_we = 1'b1; w.nx_wa = SEL_IDX; w.nx_wd = SEL_RN;
            w.y_ld  = TMP_RN;
         end
         STEP_P4: begin
            w.pv_we  = 1'b1; w.pv_wa = SEL_Y;    w.pv_wd = SEL_IDX;
            w.nx_we  = 1'b1; w.nx_wa = SEL_USED; w.nx_wd = SEL_IDX;
            w.use_we = 1'b1; w.use_wd = 1'b1;
            w.dat_we = 1'b1;
            w.fin    = FIN_RESULT; w.status = STATUS_OK; w.grant = 1'b1;
         end
         STEP_PN: begin
            w.cond   = COND_FULL;
            w.target = STEP_PFULL;
         end
         // fresh slot at the high-water mark
         STEP_PN2: begin
            w.idx_ld = IDX_HW;
            w.nx_ra  = SEL_USED;
            w.cond   = COND_ALWAYS;
            w.target = STEP_P3;
         end
         STEP_PFULL: begin
            w.fin = FIN_RESULT; w.status = STATUS_FULL;
         end
         // read links and use bit of the slot
         STEP_Q0: begin
            w.nx_ra  = SEL_IDX;
            w.pv_ra  = SEL_IDX;
            w.cond   = COND_RANGE_BAD;
            w.target = STEP_QBAD;
         end
         // keep neighbors, read free-list tail
         STEP_Q1: begin
            w.x_ld   = TMP_RP;
            w.y_ld   = TMP_RN;
            w.pv_ra  = SEL_FREE;
            w.cond   = COND_NOT_USED;
            w.target = STEP_QBAD;
         end
         // unlink from used list
         STEP_Q2: begin
            w.nx_we = 1'b1; w.nx_wa = SEL_X; w.nx_wd = SEL_Y;
            w.pv_we = 1'b1; w.pv_wa = SEL_Y; w.pv_wd = SEL_X;
            w.y_ld  = TMP_RP;
         end
         // append at free-list tail
         STEP_Q3: begin
            w.nx_we  = 1'b1; w.nx_wa = SEL_IDX;  w.nx_wd = SEL_FREE;
            w.pv_we  = 1'b1; w.pv_wa = SEL_FREE; w.pv_wd = SEL_IDX;
            w.use_we = 1'b1; w.use_wd = 1'b0;
         end
         STEP_Q4: begin
            w.nx_we = 1'b1; w.nx_wa = SEL_Y;   w.nx_wd = SEL_IDX;
            w.pv_we = 1'b1; w.pv_wa = SEL_IDX; w.pv_wd = SEL_Y;
            w.fin   = FIN_RESULT; w.status = STATUS_OK;
         end
         STEP_QBAD: begin
            w.fin = FIN_RESULT; w.status = STATUS_INVALID;
         end
         // self-link both heads
         STEP_I0: begin
            w.nx_we = 1'b1; w.nx_wa = SEL_FREE; w.nx_wd = SEL_FREE;
            w.pv_we = 1'b1; w.pv_wa = SEL_FREE; w.pv_wd = SEL_FREE;
         end
         STEP_I1: begin
            w.nx_we = 1'b1; w.nx_wa = SEL_USED; w.nx_wd = SEL_USED;
            w.pv_we = 1'b1; w.pv_wa = SEL_USED; w.pv_wd = SEL_USED;
            w.fin   = FIN_QUIET;
         end
         default: begin
            w = CTL_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/slla_sequencer.sv @@
// ----------------------------------------------------------------------------
// Slot allocator sequencer
// Step counter over the microcode store with conditional jumps.
// ----------------------------------------------------------------------------
module slla_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               start_pop,
   input  logic               rsp_hold,
   input  slla_pkg::flag_type flags,
   output slla_pkg::ctl_type  ctl,
   output logic               busy
);
   import slla_pkg::*;

   step_type pc_ff, pc_in;
   logic     run_ff, run_in;
   ctl_type  word;
   logic     stall;
   logic     take_jump;

   // current control word
   always_comb begin
      word  = rom_word(pc_ff);
      stall = run_ff && (word.fin == FIN_RESULT) && rsp_hold;
      ctl   = (run_ff && !stall) ? word : CTL_NOP;
   end

   // branch decision
   always_comb begin
      unique case (word.cond)
         COND_NONE:      take_jump = 1'b0;
         COND_ALWAYS:    take_jump = 1'b1;
         COND_RN_ZERO:   take_jump = flags.rn_zero;
         COND_FULL:      take_jump = flags.full;
         COND_RANGE_BAD: take_jump = flags.range_bad;
         COND_NOT_USED:  take_jump = !flags.in_use;
         default:        take_jump = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      pc_in  = pc_ff;
      run_in = run_ff;
      priority if (start) begin
         pc_in  = start_pop ? STEP_Q0 : STEP_P0;
         run_in = 1'b1;
      end else if (run_ff && !stall) begin
         if (word.fin != FIN_NONE) begin
            run_in = 1'b0;
         end else if (take_jump) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + STEP_W'(1);
         end
      end else begin
         run_in = run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= STEP_I0;
         run_ff <= 1'b1;
      end else begin
         pc_ff  <= pc_in;
         run_ff <= run_in;
      end
   end

   assign busy = run_ff;

endmodule

@@ rtl/slla_datapath.sv @@
// ----------------------------------------------------------------------------
// Slot allocator datapath
// Link, use-bit and data memories with slot, temp and high-water registers.
// ----------------------------------------------------------------------------
module slla_datapath #(
   parameter int CAPACITY   = slla_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = slla_pkg::DEF_DATA_WIDTH,
   localparam int IDX_W     = $clog2(CAPACITY)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [slla_pkg::PAYLOAD_W-1:0] req_payload,
   input  logic [slla_pkg::SLOT_W-1:0]    req_slot,
   input  slla_pkg::ctl_type              ctl,
   output slla_pkg::flag_type             flags,
   output logic [IDX_W-1:0]               slot_idx
);
   import slla_pkg::*;

   localparam int HW_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W = (HW_W > SLOT_W) ? HW_W : SLOT_W;

   // memories
   logic [IDX_W-1:0]      next_mem [CAPACITY];
   logic [IDX_W-1:0]      prev_mem [CAPACITY];
   logic                  use_mem  [CAPACITY];
   logic [DATA_WIDTH-1:0] data_mem [CAPACITY];

   // registers
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      x_ff, x_in;
   logic [IDX_W-1:0]      y_ff, y_in;
   logic [IDX_W-1:0]      rn_ff;
   logic [IDX_W-1:0]      rp_ff;
   logic                  ru_ff;
   logic [HW_W-1:0]       hw_ff, hw_in;
   logic                  range_bad_ff, range_bad_in;
   logic [DATA_WIDTH-1:0] payload_ff;

   logic [IDX_W-1:0] nx_raddr, pv_raddr;
   logic [IDX_W-1:0] nx_waddr, nx_wdata;
   logic [IDX_W-1:0] pv_waddr, pv_wdata;

   function automatic logic [IDX_W-1:0] pick(
      input sel_type          s,
      input logic [IDX_W-1:0] idx,
      input logic [IDX_W-1:0] x,
      input logic [IDX_W-1:0] y,
      input logic [IDX_W-1:0] rn,
      input logic [IDX_W-1:0] rp
   );
      logic [IDX_W-1:0] v;
      unique case (s)
         SEL_FREE: v = IDX_W'(FREE_HEAD);
         SEL_USED: v = IDX_W'(USED_HEAD);
         SEL_IDX:  v = idx;
         SEL_X:    v = x;
         SEL_Y:    v = y;
         SEL_RN:   v = rn;
         SEL_RP:   v = rp;
         default:  v = '0;
      endcase
      return v;
   endfunction

   // operand selection
   always_comb begin
      nx_raddr = pick(ctl.nx_ra, idx_ff, x_ff, y_ff, rn_ff, rp_ff);
      pv_raddr = pick(ctl.pv_ra, idx_ff, x_ff, y_ff, rn_ff, rp_ff);
      nx_waddr = pick(ctl.nx_wa, idx_ff, x_ff, y_ff, rn_ff, rp_ff);
      nx_wdata = pick(ctl.nx_wd, idx_ff, x_ff, y_ff, rn_ff, rp_ff);
      pv_waddr = pick(ctl.pv_wa, idx_ff, x_ff, y_ff, rn_ff, rp_ff);
      pv_wdata = pick(ctl.pv_wd, idx_ff, x_ff, y_ff, rn_ff, rp_ff);
   end

   // link memories, registered reads
   always_ff @(posedge clock) begin
      if (ctl.nx_we) begin
         next_mem[nx_waddr] <= nx_wdata;
      end
      rn_ff <= next_mem[nx_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.pv_we) begin
         prev_mem[pv_waddr] <= pv_wdata;
      end
      rp_ff <= prev_mem[pv_raddr];
   end

   // use bits, always addressed by the slot register
   always_ff @(posedge clock) begin
      if (ctl.use_we) begin
         use_mem[idx_ff] <= ctl.use_wd;
      end
      ru_ff <= use_mem[idx_ff];
   end

   // stored words
   always_ff @(posedge clock) begin
      if (ctl.dat_we) begin
         data_mem[idx_ff] <= payload_ff;
      end
   end

   // slot, temp and high-water updates
   always_comb begin
      idx_in       = idx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      hw_in        = hw_ff;
      range_bad_in = range_bad_ff;
      if (start) begin
         idx_in       = IDX_W'(req_slot);
         range_bad_in = (CMP_W'(req_slot) <= CMP_W'(USED_HEAD)) ||
                        (CMP_W'(req_slot) >= CMP_W'(hw_ff));
      end else begin
         unique case (ctl.idx_ld)
            IDX_KEEP: idx_in = idx_ff;
            IDX_RN:   idx_in = rn_ff;
            IDX_HW: begin
               idx_in = IDX_W'(hw_ff);
               hw_in  = hw_ff + HW_W'(1);
            end
            default:  idx_in = idx_ff;
         endcase
      end
      unique case (ctl.x_ld)
         TMP_KEEP: x_in = x_ff;
         TMP_RN:   x_in = rn_ff;
         TMP_RP:   x_in = rp_ff;
         default:  x_in = x_ff;
      endcase
      unique case (ctl.y_ld)
         TMP_KEEP: y_in = y_ff;
         TMP_RN:   y_in = rn_ff;
         TMP_RP:   y_in = rp_ff;
         default:  y_in = y_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= HW_W'(USED_HEAD + 1);
      end else begin
         hw_ff <= hw_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      range_bad_ff <= range_bad_in;
      if (start) begin
         payload_ff <= DATA_WIDTH'(req_payload);
      end
   end

   // flags for the sequencer
   assign flags.rn_zero   = (rn_ff == IDX_W'(FREE_HEAD));
   assign flags.full      = (hw_ff == HW_W'(CAPACITY));
   assign flags.range_bad = range_bad_ff;
   assign flags.in_use    = ru_ff;

   assign slot_idx = idx_ff;

endmodule

@@ rtl/static_linked_list_allocator_top.sv @@
// ----------------------------------------------------------------------------
// Static linked-list slot allocator
// Free and used slot lists, doubly linked through link memories, run by a
// small microcode program.
// ----------------------------------------------------------------------------
//  channel  | dir | words                      | fields, low bit up
//  req_     | in  | one per push or pop        | tdata: payload, slot_index; tuser: mode
//  rsp_     | out | one per accepted req word  | tdata: granted_slot, status
//
//  a push takes a slot from the free list, a fresh slot, or fails on a full table;
//  a pop runs to the end or is rejected early; the next word is taken the
//  cycle after the last step. The number of steps is set by the link memories:
//  one write and one registered read per memory and cycle.
//  after reset the two head entries are written while req_tready stays low.
//  a finished result waits in the output register; a new word is accepted
//  meanwhile and stalls only at its last step while that register is full.
// ----------------------------------------------------------------------------
`include "static_linked_list_allocator_top_defines.svh"

module static_linked_list_allocator_top #(
   parameter int CAPACITY   = slla_pkg::DEF_CAPACITY,
   parameter int DATA_WIDTH = slla_pkg::DEF_DATA_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // req: tdata = payload[31:0], slot_index[39:32]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [slla_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req: tuser = mode (0 push, 1 pop)
   input  logic                             req_tuser,
   // rsp: tdata = granted_slot[7:0], status[9:8], zero fill
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [slla_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import slla_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic             accept;
   logic             busy;
   logic             rsp_hold;
   ctl_type          ctl;
   flag_type         flags;
   logic [IDX_W-1:0] slot_idx;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_granted_ff, rsp_granted_in;
   status_type        rsp_status_ff, rsp_status_in;

   // input handshake
   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign rsp_hold   = rsp_valid_ff && !rsp_tready;

   slla_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .start_pop (req_tuser),
      .rsp_hold  (rsp_hold),
      .flags     (flags),
      .ctl       (ctl),
      .busy      (busy)
   );

   slla_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .req_payload (req_tdata[PAYLOAD_W-1:0]),
      .req_slot    (req_tdata[PAYLOAD_W +: SLOT_W]),
      .ctl         (ctl),
      .flags       (flags),
      .slot_idx    (slot_idx)
   );

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      priority if (ctl.fin == FIN_RESULT) begin
         rsp_valid_in   = 1'b1;
         rsp_granted_in = ctl.grant ? SLOT_W'(slot_idx) : '0;
         rsp_status_in  = ctl.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - SLOT_W - STATUS_W){1'b0}},
                        rsp_status_ff, rsp_granted_ff};

   // checks
   `SLLA_ASSERT(a_no_result_overwrite, (ctl.fin == FIN_RESULT) |-> !rsp_hold, "result overwritten")
   `SLLA_ASSERT(a_accept_starts_work, accept |=> busy, "accepted word did not start")
   `SLLA_ASSERT(a_head_never_granted, ctl.grant |-> slot_idx > IDX_W'(USED_HEAD), "head granted")
   `SLLA_ASSERT(a_result_after_work, $rose(rsp_valid_ff) |-> $past(busy), "result without work")

endmodule
